// ===== rtl/core/assert_macros.svh =====
// Shared assertion macros; every user clocks on clock and is quiet during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/lpmd_pkg.sv =====
package lpmd_pkg;

   localparam int unsigned PrefixBytes = 5;
   localparam int unsigned CountWidth = $clog2(PrefixBytes);
   localparam logic [CountWidth-1:0] LastPrefixCount = CountWidth'(PrefixBytes - 1);

   typedef enum logic [1:0] {
      PH_PREFIX  = 2'd0,
      PH_PAYLOAD = 2'd1,
      PH_ERROR   = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_EMPTY   = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
      logic       message_end;
   } result_type;

endpackage

// ===== rtl/core/lpmd_parser.sv =====
`include "assert_macros.svh"

module lpmd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           stream_byte,
   input  logic                 restart,
   output logic                 result_valid,
   output lpmd_pkg::result_type result
);

   lpmd_pkg::phase_type              phase_ff, phase_in;
   logic [lpmd_pkg::CountWidth-1:0]  count_ff, count_in;
   logic                             flag_ff, flag_in;
   logic [31:0]                      remaining_ff, remaining_in;

   lpmd_pkg::phase_type              cur_phase;
   logic [lpmd_pkg::CountWidth-1:0]  cur_count;
   logic                             cur_flag;
   logic [31:0]                      cur_remaining;
   logic [31:0]                      shifted;
   logic [31:0]                      decremented;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lpmd_pkg::PH_PREFIX;
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         remaining_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         remaining_ff <= remaining_in;
      end
   end

   always_comb begin
      // restart clears everything before this byte is looked at
      cur_phase     = restart ? lpmd_pkg::PH_PREFIX : phase_ff;
      cur_count     = restart ? '0 : count_ff;
      cur_flag      = restart ? 1'b0 : flag_ff;
      cur_remaining = restart ? '0 : remaining_ff;
      shifted       = {cur_remaining[23:0], stream_byte};
      decremented   = cur_remaining - 32'd1;

      phase_in     = cur_phase;
      count_in     = cur_count;
      flag_in      = cur_flag;
      remaining_in = cur_remaining;

      result_valid        = 1'b0;
      result.kind         = lpmd_pkg::KIND_PAYLOAD;
      result.payload_byte = '0;
      result.message_end  = 1'b0;

      case (cur_phase)
         lpmd_pkg::PH_ERROR: begin
            // drop until restart
         end
         lpmd_pkg::PH_PAYLOAD: begin
            remaining_in        = decremented;
            result_valid        = 1'b1;
            result.payload_byte = stream_byte;
            if (decremented == '0) begin
               phase_in           = lpmd_pkg::PH_PREFIX;
               count_in           = '0;
               result.message_end = 1'b1;
            end
         end
         default: begin
            // prefix phase; the unused phase code starts a fresh prefix
            if (cur_phase != lpmd_pkg::PH_PREFIX) begin
               phase_in = lpmd_pkg::PH_PREFIX;
            end
            if (cur_phase != lpmd_pkg::PH_PREFIX || cur_count == '0) begin
               flag_in      = (stream_byte != 8'd0);
               remaining_in = '0;
               count_in     = lpmd_pkg::CountWidth'(1);
            end else if (cur_count != lpmd_pkg::LastPrefixCount) begin
               remaining_in = shifted;
               count_in     = cur_count + lpmd_pkg::CountWidth'(1);
            end else begin
               count_in     = '0;
               result_valid = 1'b1;
               if (cur_flag) begin
                  phase_in     = lpmd_pkg::PH_ERROR;
                  remaining_in = '0;
                  result.kind  = lpmd_pkg::KIND_ERROR;
               end else if (shifted == '0) begin
                  phase_in           = lpmd_pkg::PH_PREFIX;
                  remaining_in       = '0;
                  result.kind        = lpmd_pkg::KIND_EMPTY;
                  result.message_end = 1'b1;
               end else begin
                  phase_in     = lpmd_pkg::PH_PAYLOAD;
                  remaining_in = shifted;
                  result_valid = 1'b0;
               end
            end
         end
      endcase
   end

   `ASSERT_NEXT(a_error_sticks, accept && result_valid && result.kind == lpmd_pkg::KIND_ERROR,
      phase_ff == lpmd_pkg::PH_ERROR, "error result did not enter error phase")
   `ASSERT_IMPLY(a_payload_count, phase_ff == lpmd_pkg::PH_PAYLOAD, remaining_ff != '0,
      "payload phase with nothing left to count")
   `ASSERT_IMPLY(a_prefix_range, 1'b1, count_ff <= lpmd_pkg::LastPrefixCount,
      "prefix count out of range")

endmodule

// ===== rtl/core/lpmd_out_buf.sv =====
`include "assert_macros.svh"

module lpmd_out_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   input  lpmd_pkg::result_type in_data,
   output logic                 full,
   input  logic                 out_ready,
   output logic                 out_valid,
   output lpmd_pkg::result_type out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   lpmd_pkg::result_type main_ff, main_in;
   lpmd_pkg::result_type skid_ff, skid_in;
   logic                 out_fire;

   assign out_fire  = main_valid_ff && out_ready;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         // input is held off while the skid entry is occupied
         if (out_fire) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!main_valid_ff || out_fire) begin
         main_valid_in = in_valid;
         main_in       = in_data;
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   `ASSERT_IMPLY(a_skid_behind_main, skid_valid_ff, main_valid_ff,
      "skid entry held without a result in front")
   `ASSERT_NEXT(a_skid_kept, skid_valid_ff && !out_ready, skid_valid_ff,
      "skid entry lost while output stalled")

endmodule

// ===== rtl/core/length_prefixed_message_deframer_core.sv =====
// Each result is registered in the output stage before it appears on rsp_.
// Throughput: one byte per cycle; a two-entry output stage lets bytes keep
// flowing while one result waits, and req_ready drops only when both are full.
// Prefix bytes, dropped bytes and bytes with no result complete in their cycle.
// Reset (synchronous, active high) returns to the prefix phase, empties output.
module length_prefixed_message_deframer_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_stream_byte,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_message_end
);

   logic                 accept;
   logic                 step_valid;
   logic                 buf_full;
   lpmd_pkg::result_type step_result;
   lpmd_pkg::result_type rsp_result;

   assign req_ready = !buf_full;
   assign accept    = req_valid && req_ready;

   lpmd_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .stream_byte  (req_stream_byte),
      .restart      (req_restart),
      .result_valid (step_valid),
      .result       (step_result)
   );

   lpmd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept && step_valid),
      .in_data   (step_result),
      .full      (buf_full),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (rsp_result)
   );

   assign rsp_result_kind  = rsp_result.kind;
   assign rsp_payload_byte = rsp_result.payload_byte;
   assign rsp_message_end  = rsp_result.message_end;

endmodule

// ===== verif/length_prefixed_message_deframer_core_tb.sv =====
module length_prefixed_message_deframer_core_tb;

   localparam int unsigned RandomItems = 850;
   localparam int unsigned CycleLimit  = 500_000;
   localparam int unsigned DrainCycles = 8;

   typedef struct {
      logic [7:0] data;
      logic       restart;
      int         idle_after;
   } stream_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_stream_byte = 8'h00;
   logic       req_restart = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_payload_byte;
   logic       rsp_message_end;

   length_prefixed_message_deframer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_stream_byte  (req_stream_byte),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_message_end  (rsp_message_end)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   stream_item_type      pending_items[$];
   lpmd_pkg::result_type expected_results[$];

   // deframer state mirrored by the predictor
   lpmd_pkg::phase_type             frame_phase = lpmd_pkg::PH_PREFIX;
   logic [lpmd_pkg::CountWidth-1:0] prefix_seen = '0;
   logic                            flag_set = 1'b0;
   logic [31:0]                     bytes_left = '0;

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned fed_count = 0;
   int unsigned restart_count = 0;
   int unsigned payload_seen = 0;
   int unsigned end_seen = 0;
   int unsigned empty_seen = 0;
   int unsigned flag_error_seen = 0;
   bit          counting = 1'b0;
   int          gap_mode = 1;
   logic        req_taken = 1'b0;

   function automatic bit deframe_byte(input logic [7:0] data, input logic restart,
                                       output lpmd_pkg::result_type res);
      res = '{kind: lpmd_pkg::KIND_PAYLOAD, payload_byte: 8'h00,
              message_end: 1'b0};
      if (restart) begin
         frame_phase = lpmd_pkg::PH_PREFIX;
         prefix_seen = '0;
         flag_set = 1'b0;
         bytes_left = '0;
      end
      case (frame_phase)
         lpmd_pkg::PH_ERROR: return 1'b0;
         lpmd_pkg::PH_PAYLOAD: begin
            bytes_left = bytes_left - 32'd1;
            res.payload_byte = data;
            res.message_end = (bytes_left == 32'd0);
            if (bytes_left == 32'd0) begin
               frame_phase = lpmd_pkg::PH_PREFIX;
               prefix_seen = '0;
            end
            return 1'b1;
         end
         default: begin
            if (prefix_seen == '0) begin
               flag_set = (data != 8'h00);
               bytes_left = '0;
               prefix_seen = lpmd_pkg::CountWidth'(1);
               return 1'b0;
            end
            bytes_left = {bytes_left[23:0], data};
            if (prefix_seen < lpmd_pkg::LastPrefixCount) begin
               prefix_seen = prefix_seen + 1'b1;
               return 1'b0;
            end
            prefix_seen = '0;
            if (flag_set) begin
               frame_phase = lpmd_pkg::PH_ERROR;
               bytes_left = '0;
               res.kind = lpmd_pkg::KIND_ERROR;
               return 1'b1;
            end
            if (bytes_left == 32'd0) begin
               res.kind = lpmd_pkg::KIND_EMPTY;
               res.message_end = 1'b1;
               return 1'b1;
            end
            frame_phase = lpmd_pkg::PH_PAYLOAD;
            return 1'b0;
         end
      endcase
   endfunction

   function automatic int pick_gap(input int mode);
      int roll;
      roll = $urandom_range(0, 99);
      case (mode)
         0: return 0;
         1: return (roll < 25) ? $urandom_range(1, 2) : 0;
         default: begin
            if (roll < 60) return 0;
            if (roll < 92) return $urandom_range(1, 3);
            return $urandom_range(8, 30);
         end
      endcase
   endfunction

   function automatic int pick_stall(input int mode);
      case (mode)
         0: return 0;
         1: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
         default: begin
            if ($urandom_range(0, 4) != 0) return 0;
            return ($urandom_range(0, 5) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 4);
         end
      endcase
   endfunction

   task automatic push_item(input logic [7:0] data, input logic restart, input bit dropped);
      stream_item_type item;
      item.data = data;
      item.restart = restart;
      item.idle_after = pick_gap(gap_mode);
      pending_items.push_back(item);
      if (restart) restart_count++;
      if (counting && !dropped) fed_count++;
   endtask

   task automatic push_prefix(input logic [7:0] flag, input logic [31:0] length,
                              input logic restart);
      push_item(flag, restart, 1'b0);
      push_item(length[31:24], 1'b0, 1'b0);
      push_item(length[23:16], 1'b0, 1'b0);
      push_item(length[15:8], 1'b0, 1'b0);
      push_item(length[7:0], 1'b0, 1'b0);
   endtask

   // Well-formed messages dominate; the rest are flag errors, cut-off messages and noise,
   // each followed by a restart so framing recovers.
   task automatic fill_random_stream();
      int          choice;
      int          cut;
      int unsigned msg_index;
      logic [31:0] length;
      logic        first_restart;
      bit          need_restart;
      msg_index = 0;
      need_restart = 1'b0;
      counting = 1'b1;
      while (fed_count < RandomItems) begin
         if (msg_index % 30 == 0) gap_mode = $urandom_range(0, 2);
         msg_index++;
         choice = $urandom_range(0, 99);
         first_restart = need_restart || ($urandom_range(0, 19) == 0);
         need_restart = 1'b0;
         if (choice < 70) begin
            cut = $urandom_range(0, 99);
            if (cut < 10) length = 0;
            else if (cut < 70) length = $urandom_range(1, 8);
            else if (cut < 95) length = $urandom_range(9, 40);
            else length = $urandom_range(41, 300);
            push_prefix(8'h00, length, first_restart);
            repeat (length) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         end else if (choice < 80) begin
            push_prefix(8'($urandom_range(1, 255)), $urandom, first_restart);
            repeat ($urandom_range(0, 4))
               push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            need_restart = 1'b1;
         end else if (choice < 92) begin
            // cut off inside the prefix or the payload, or stop at the end of a short message
            length = ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(1, 20);
            cut = $urandom_range(1, 12);
            for (int k = 0; k < cut; k++) begin
               if (k >= 5 && (k - 5) >= length) break;
               if (k == 0) push_item(8'h00, first_restart, 1'b0);
               else if (k < 5) push_item(length[8*(4-k) +: 8], 1'b0, 1'b0);
               else push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            need_restart = 1'b1;
         end else begin
            repeat ($urandom_range(1, 6))
               push_item(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0, 1'b0);
            need_restart = 1'b1;
         end
      end
   endtask

   // feed the request channel; idle after an item as its gap says
   int              idle_left = 0;
   stream_item_type drive_item;

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (idle_left > 0) begin
            req_valid <= 1'b0;
            idle_left--;
         end else if (pending_items.size() != 0) begin
            drive_item = pending_items.pop_front();
            req_valid <= 1'b1;
            req_stream_byte <= drive_item.data;
            req_restart <= drive_item.restart;
            idle_left = drive_item.idle_after;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result channel back-pressure, switching between calm and busy stretches
   int stall_left = 0;
   int stall_len = 0;
   int ready_mode = 0;
   int mode_timer = 0;

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left--;
      end else begin
         stall_len = pick_stall(ready_mode);
         rsp_ready <= (stall_len == 0);
         stall_left = (stall_len > 0) ? stall_len - 1 : 0;
      end
      if (mode_timer == 0) begin
         ready_mode = $urandom_range(0, 2);
         mode_timer = $urandom_range(150, 300);
      end else begin
         mode_timer--;
      end
   end

   always @(posedge clock) begin : result_monitor
      lpmd_pkg::result_type want;
      lpmd_pkg::result_type predicted;
      cycle_count <= cycle_count + 1;
      req_taken <= req_valid && req_ready && !reset;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: result with none expected: kind %0d byte %02h end %0b",
                        $time, rsp_result_kind, rsp_payload_byte, rsp_message_end);
            end else begin
               want = expected_results.pop_front();
               if (rsp_result_kind !== want.kind || rsp_payload_byte !== want.payload_byte
                   || rsp_message_end !== want.message_end) begin
                  error_count++;
                  $display("%0t: expected kind %0d byte %02h end %0b,",
                           $time, want.kind, want.payload_byte, want.message_end,
                           " got kind %0d byte %02h end %0b",
                           rsp_result_kind, rsp_payload_byte, rsp_message_end);
               end
               case (want.kind)
                  lpmd_pkg::KIND_PAYLOAD: payload_seen++;
                  lpmd_pkg::KIND_EMPTY:   empty_seen++;
                  default:                flag_error_seen++;
               endcase
               if (want.kind == lpmd_pkg::KIND_PAYLOAD && want.message_end) end_seen++;
            end
         end
         if (req_valid && req_ready) begin
            if (deframe_byte(req_stream_byte, req_restart, predicted))
               expected_results.push_back(predicted);
         end
      end
   end

   initial begin
      // length one, then the largest length cut short by a restart
      push_prefix(8'h00, 32'd1, 1'b0);
      push_item(8'hFF, 1'b0, 1'b0);
      push_prefix(8'h00, 32'hFFFF_FFFF, 1'b0);
      push_item(8'hAA, 1'b0, 1'b0);
      push_prefix(8'h00, 32'd2, 1'b1);
      push_item(8'h00, 1'b0, 1'b0);
      push_item(8'h5A, 1'b0, 1'b0);
      // nonzero flag, a dropped byte, then recover with an empty message
      push_prefix(8'h80, 32'd3, 1'b0);
      push_item(8'h77, 1'b0, 1'b1);
      push_prefix(8'h00, 32'd0, 1'b1);
      fill_random_stream();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while ((pending_items.size() != 0 || req_valid || expected_results.size() != 0)
             && cycle_count < CycleLimit)
         @(negedge clock);

      if (cycle_count >= CycleLimit) begin
         $display("%0t: timeout with %0d items pending and %0d results outstanding",
                  $time, pending_items.size(), expected_results.size());
         $display("length_prefixed_message_deframer_core_tb NOT OK");
      end else begin
         repeat (DrainCycles) @(posedge clock);
         if (expected_results.size() != 0) begin
            error_count++;
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
         end
         $display("Fed %0d random bytes plus a directed opener, %0d with restart set.",
                  fed_count, restart_count);
         $display("Checked %0d payload bytes (%0d message ends),", payload_seen, end_seen,
                  " %0d empty messages, %0d flag errors.", empty_seen, flag_error_seen);
         if (error_count == 0)
            $display("length_prefixed_message_deframer_core_tb OK");
         else
            $display("length_prefixed_message_deframer_core_tb NOT OK");
      end
      $finish;
   end

endmodule
